// File: design/brfifo_pkg.sv
// ============================================================================
// brfifo_pkg
// Shared types and constants of the byte ring FIFO with word access.
// ============================================================================
package brfifo_pkg;

    // Ring size; one slot always stays empty, so SLOTS-1 bytes at most.
    localparam int SLOTS  = 4096;
    localparam int PTR_W  = $clog2(SLOTS);
    localparam int OFS_W  = 12;                    // offset and count fields
    localparam int DATA_W = 32;
    localparam int CNT_W  = 3;                     // byte count field
    localparam int CMP_W  = (PTR_W > OFS_W) ? PTR_W : OFS_W;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);
    localparam logic [PTR_W:0]   SLOTS_X   = (PTR_W + 1)'(SLOTS);
    localparam logic [CNT_W-1:0] MAX_BYTES = CNT_W'(4);
    localparam logic [CNT_W-1:0] PEEK_BYTES = CNT_W'(2);

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_FIND = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_SHORT = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_PUSH,
        S_FIXRP,
        S_POP,
        S_PEEK,
        S_DRAIN,
        S_FIND,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    load;         // latch the accepted item
        logic    mem_we;       // write one byte at the write pointer
        logic    mem_re;       // read one byte at read pointer + index
        logic    wp_adv;
        logic    rp_adv;
        logic    idx_adv;
        logic    rem_dec;
        logic    fix_rp;       // read pointer to one past write pointer
        logic    set_status;
        t_status status;
        logic    found_match;
        logic    found_used;
        logic    out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_opcode op;
        logic    cnt_zero;
        logic    pop_short;
        logic    peek_short;
        logic    overflow;
        logic    ovw;
        logic    find_none;
        logic    rem_last;
        logic    idx_end;
        logic    pend;
        logic    match;
        logic    out_free;
    } t_stat;

endpackage

// File: design/byte_ring_fifo_with_word_access.sv
// ============================================================================
// byte_ring_fifo_with_word_access
// Byte ring FIFO with push, pop, peek and find over a word-wide stream.
// ============================================================================
// A ring of SLOTS bytes (4096) of which one slot always stays empty, so it
// holds at most SLOTS-1 bytes. Each input transfer carries one command: push
// writes 1 to 4 bytes of a word, most significant first; pop removes 1 to 4
// bytes and returns them big-endian; peek returns the two oldest bytes
// without removing them; find returns the offset of the first byte equal to
// the search byte at or after the search offset, or the used count when none
// matches. Counts above four act as four; a count of zero does nothing.
// A push that does not fit is refused with "no room", or, with the overwrite
// mode bit set, written anyway with the oldest bytes dropped so the ring ends
// full. Every result carries the used count after the command. The byte store
// has one port, one byte per cycle, and that sets the timing. A push writes
// its bytes one by one and, when it overwrites, then moves the read pointer;
// a pop or peek reads its bytes one by one; a refused or zero-count command,
// or a find whose offset is at or past the used count, reads or writes no
// byte; a find reads bytes until the last byte read matches or the used
// count is reached. One command is worked at a time; the next can be taken
// in the cycle after its result is loaded into the output register, even if
// the downstream side has not yet taken it. The mode bit may be written at
// any time the block is idle; the write is always taken at once.
// ============================================================================
module byte_ring_fifo_with_word_access (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] byte_count, [34:3] push_data, [42:35] search_byte,
    // [54:43] search_offset, [55] zero
    input  logic [55:0] i_s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  i_s_axis_tuser,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] read_data, [33:32] status, [45:34] found_offset,
    // [57:46] used_count, [58] overwrote, [63:59] zero
    output logic [63:0] o_m_axis_tdata,
    // overwrite mode register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    brfifo_pkg::t_cmd    cmd;
    brfifo_pkg::t_stat   stat;
    brfifo_pkg::t_status res_status;

    logic [brfifo_pkg::DATA_W-1:0] res_read_data;
    logic [brfifo_pkg::OFS_W-1:0]  res_found, res_used;
    logic                          res_over;

    // mode writes never stall
    assign o_cfg_ready = 1'b1;

    brfifo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    brfifo_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (brfifo_pkg::t_opcode'(i_s_axis_tuser)),
        .i_byte_count    (i_s_axis_tdata[2:0]),
        .i_push_data     (i_s_axis_tdata[34:3]),
        .i_search_byte   (i_s_axis_tdata[42:35]),
        .i_search_offset (i_s_axis_tdata[54:43]),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_read_data     (res_read_data),
        .o_status        (res_status),
        .o_found_offset  (res_found),
        .o_used_count    (res_used),
        .o_overwrote     (res_over)
    );

    // Result packing, first field lowest
    assign o_m_axis_tdata = {5'b0, res_over, res_used, res_found,
                             res_status, res_read_data};

endmodule

// File: design/brfifo_ctrl.sv
// ============================================================================
// brfifo_ctrl
// Operation sequencer: decodes the item, steps the byte loops, hands over
// the result.
// ============================================================================
module brfifo_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  brfifo_pkg::t_stat   i_stat,
    output brfifo_pkg::t_cmd    o_cmd
);

    brfifo_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brfifo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.status = brfifo_pkg::STAT_OK;

        unique case (r_state)
            brfifo_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = brfifo_pkg::S_CHECK;
                end
            end

            brfifo_pkg::S_CHECK: begin
                unique case (i_stat.op)
                    brfifo_pkg::OP_PUSH: begin
                        priority if (i_stat.cnt_zero) begin
                            n_state = brfifo_pkg::S_DONE;
                        end else if (i_stat.overflow && !i_stat.ovw) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = brfifo_pkg::STAT_FULL;
                            n_state          = brfifo_pkg::S_DONE;
                        end else begin
                            n_state = brfifo_pkg::S_PUSH;
                        end
                    end
                    brfifo_pkg::OP_POP: begin
                        priority if (i_stat.cnt_zero) begin
                            n_state = brfifo_pkg::S_DONE;
                        end else if (i_stat.pop_short) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = brfifo_pkg::STAT_SHORT;
                            n_state          = brfifo_pkg::S_DONE;
                        end else begin
                            n_state = brfifo_pkg::S_POP;
                        end
                    end
                    brfifo_pkg::OP_PEEK: begin
                        if (i_stat.peek_short) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = brfifo_pkg::STAT_SHORT;
                            n_state          = brfifo_pkg::S_DONE;
                        end else begin
                            n_state = brfifo_pkg::S_PEEK;
                        end
                    end
                    default: begin
                        if (i_stat.find_none) begin
                            o_cmd.found_used = 1'b1;
                            n_state          = brfifo_pkg::S_DONE;
                        end else begin
                            n_state = brfifo_pkg::S_FIND;
                        end
                    end
                endcase
            end

            brfifo_pkg::S_PUSH: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.wp_adv  = 1'b1;
                o_cmd.rem_dec = 1'b1;
                if (i_stat.rem_last) begin
                    n_state = i_stat.overflow ? brfifo_pkg::S_FIXRP : brfifo_pkg::S_DONE;
                end
            end

            brfifo_pkg::S_FIXRP: begin
                o_cmd.fix_rp = 1'b1;
                n_state      = brfifo_pkg::S_DONE;
            end

            brfifo_pkg::S_POP: begin
                o_cmd.mem_re  = 1'b1;
                o_cmd.rp_adv  = 1'b1;
                o_cmd.rem_dec = 1'b1;
                if (i_stat.rem_last) begin
                    n_state = brfifo_pkg::S_DRAIN;
                end
            end

            brfifo_pkg::S_PEEK: begin
                o_cmd.mem_re  = 1'b1;
                o_cmd.idx_adv = 1'b1;
                o_cmd.rem_dec = 1'b1;
                if (i_stat.rem_last) begin
                    n_state = brfifo_pkg::S_DRAIN;
                end
            end

            brfifo_pkg::S_DRAIN: begin
                n_state = brfifo_pkg::S_DONE;
            end

            brfifo_pkg::S_FIND: begin
                priority if (i_stat.match) begin
                    o_cmd.found_match = 1'b1;
                    n_state           = brfifo_pkg::S_DONE;
                end else if (!i_stat.idx_end) begin
                    o_cmd.mem_re  = 1'b1;
                    o_cmd.idx_adv = 1'b1;
                end else if (!i_stat.pend) begin
                    o_cmd.found_used = 1'b1;
                    n_state          = brfifo_pkg::S_DONE;
                end else begin
                    n_state = brfifo_pkg::S_FIND;
                end
            end

            brfifo_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = brfifo_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = brfifo_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: design/brfifo_dp.sv
// ============================================================================
// brfifo_dp
// Datapath: byte store, ring pointers, item registers, result register.
// ============================================================================
module brfifo_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // accepted item
    input  brfifo_pkg::t_opcode             i_opcode,
    input  logic [brfifo_pkg::CNT_W-1:0]    i_byte_count,
    input  logic [brfifo_pkg::DATA_W-1:0]   i_push_data,
    input  logic [7:0]                      i_search_byte,
    input  logic [brfifo_pkg::OFS_W-1:0]    i_search_offset,
    // mode register write
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_data,
    // sequencer link
    input  brfifo_pkg::t_cmd                i_cmd,
    output brfifo_pkg::t_stat               o_stat,
    // result register
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [brfifo_pkg::DATA_W-1:0]   o_read_data,
    output brfifo_pkg::t_status             o_status,
    output logic [brfifo_pkg::OFS_W-1:0]    o_found_offset,
    output logic [brfifo_pkg::OFS_W-1:0]    o_used_count,
    output logic                            o_overwrote
);

    localparam int PW = brfifo_pkg::PTR_W;

    logic [7:0]  mem [brfifo_pkg::SLOTS];

    logic [PW-1:0]                  r_wp, r_rp, r_idx, r_cmp_idx, r_used;
    logic                           r_ovw;
    brfifo_pkg::t_opcode            r_op;
    logic [brfifo_pkg::CNT_W-1:0]   r_cnt, r_rem;
    logic [brfifo_pkg::DATA_W-1:0]  r_data, r_rdata;
    logic [7:0]                     r_sbyte, r_q;
    logic [brfifo_pkg::OFS_W-1:0]   r_soff, r_found;
    brfifo_pkg::t_status            r_status;
    logic                           r_over, r_pend;
    logic                           r_out_valid;

    logic [PW-1:0]                  used_now, scan_addr, addr, free_now;
    logic [PW:0]                    scan_sum, used_wrap;
    logic [brfifo_pkg::CNT_W-1:0]   cnt_sat;
    logic [7:0]                     wbyte;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == brfifo_pkg::LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    // Bytes stored, from the pointers as they stand
    assign used_wrap = {1'b0, r_wp} + brfifo_pkg::SLOTS_X - {1'b0, r_rp};
    assign used_now  = (r_wp >= r_rp) ? (r_wp - r_rp) : PW'(used_wrap);

    // Slot at read pointer plus index
    assign scan_sum  = {1'b0, r_rp} + {1'b0, r_idx};
    assign scan_addr = (scan_sum >= brfifo_pkg::SLOTS_X) ?
                       PW'(scan_sum - brfifo_pkg::SLOTS_X) : PW'(scan_sum);
    assign addr      = i_cmd.mem_we ? r_wp : scan_addr;

    assign cnt_sat   = (i_byte_count > brfifo_pkg::MAX_BYTES) ?
                       brfifo_pkg::MAX_BYTES : i_byte_count;
    assign free_now  = brfifo_pkg::LAST_SLOT - r_used;

    // Push goes most significant byte first: byte rem-1 of the word
    always_comb begin
        unique case (r_rem)
            3'd1:    wbyte = r_data[7:0];
            3'd2:    wbyte = r_data[15:8];
            3'd3:    wbyte = r_data[23:16];
            default: wbyte = r_data[31:24];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[addr] <= wbyte;
        end
        if (i_cmd.mem_re) begin
            r_q <= mem[addr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_ovw       <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ovw <= i_cfg_data;
            end
            if (i_cmd.wp_adv) begin
                r_wp <= advance(r_wp);
            end
            if (i_cmd.rp_adv) begin
                r_rp <= advance(r_rp);
            end else if (i_cmd.fix_rp) begin
                r_rp <= advance(r_wp);
            end
            r_pend <= i_cmd.mem_re;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_cnt    <= cnt_sat;
            r_rem    <= (i_opcode == brfifo_pkg::OP_PEEK) ? brfifo_pkg::PEEK_BYTES : cnt_sat;
            r_idx    <= (i_opcode == brfifo_pkg::OP_FIND) ? PW'(i_search_offset) : '0;
            r_data   <= i_push_data;
            r_sbyte  <= i_search_byte;
            r_soff   <= i_search_offset;
            r_used   <= used_now;
            r_rdata  <= '0;
            r_status <= brfifo_pkg::STAT_OK;
            r_found  <= '0;
            r_over   <= 1'b0;
        end else begin
            if (i_cmd.rem_dec) begin
                r_rem <= r_rem - brfifo_pkg::CNT_W'(1);
            end
            if (i_cmd.idx_adv) begin
                r_idx <= r_idx + PW'(1);
            end
            if (i_cmd.mem_re) begin
                r_cmp_idx <= r_idx;
            end
            if (r_pend && (r_op != brfifo_pkg::OP_FIND)) begin
                r_rdata <= {r_rdata[brfifo_pkg::DATA_W-9:0], r_q};
            end
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.fix_rp) begin
                r_over <= 1'b1;
            end
            if (i_cmd.found_match) begin
                r_found <= brfifo_pkg::OFS_W'(r_cmp_idx);
            end else if (i_cmd.found_used) begin
                r_found <= brfifo_pkg::OFS_W'(r_used);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_read_data    <= r_rdata;
            o_status       <= r_status;
            o_found_offset <= r_found;
            o_used_count   <= brfifo_pkg::OFS_W'(used_now);
            o_overwrote    <= r_over;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.cnt_zero   = (r_cnt == '0);
        o_stat.pop_short  = (r_used < PW'(r_cnt));
        o_stat.peek_short = (r_used < PW'(brfifo_pkg::PEEK_BYTES));
        o_stat.overflow   = (PW'(r_cnt) > free_now);
        o_stat.ovw        = r_ovw;
        o_stat.find_none  = (brfifo_pkg::CMP_W'(r_soff) >= brfifo_pkg::CMP_W'(r_used));
        o_stat.rem_last   = (r_rem == brfifo_pkg::CNT_W'(1));
        o_stat.idx_end    = (r_idx >= r_used);
        o_stat.pend       = r_pend;
        o_stat.match      = r_pend && (r_q == r_sbyte);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

endmodule
